>>> rtl/core/pool2d_pkg.sv
// Shared types, constants and the reciprocal table of the pooling block.
`default_nettype none
package pool2d_pkg;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;   // holds a 16 by 16 window sum of Q8.8 samples
  localparam int KDIM_W   = 5;    // effective kernel size, 1..16
  localparam int RECIP_SH = 28;   // scale of the reciprocal table
  localparam int RECIP_W  = 29;
  localparam int ROW_W    = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 11;
  localparam int MAX_HEIGHT = 1024;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_WIDTH  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_HEIGHT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_MODE     = 3'd6;

  localparam logic MODE_MAX = 1'b0;

  // Position of a result in the output plane.
  typedef struct packed {
    logic [ROW_W-1:0] orow;
    logic [ROW_W-1:0] ocol;
    logic             last;
  } tag_t;

  // ceil(2^28 / d); exact truncating division for magnitudes below 2^24.
  function automatic logic [RECIP_W-1:0] recip(input logic [KDIM_W-1:0] d);
    logic [RECIP_W-1:0] m;
    case (d)
      5'd2:    m = 29'd134217728;
      5'd3:    m = 29'd89478486;
      5'd4:    m = 29'd67108864;
      5'd5:    m = 29'd53687092;
      5'd6:    m = 29'd44739243;
      5'd7:    m = 29'd38347923;
      5'd8:    m = 29'd33554432;
      5'd9:    m = 29'd29826162;
      5'd10:   m = 29'd26843546;
      5'd11:   m = 29'd24403224;
      5'd12:   m = 29'd22369622;
      5'd13:   m = 29'd20648882;
      5'd14:   m = 29'd19173962;
      5'd15:   m = 29'd17895698;
      5'd16:   m = 29'd16777216;
      default: m = 29'd268435456;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/pool2d_max_avg.sv
// Streaming 2-D max and average pooling over raster-order feature-map planes.
//
// Input items arrive on the s_axis channel, one Q8.8 sample each in raster
// order. Results leave on m_axis: tdata carries the pooled value, output row
// and output column; tlast marks the final result of each output plane.
// Registers are written over the cfg channel (index, data); the user must
// write them only while the block is idle, which the block does not enforce;
// every write also restarts the plane at row 0, column 0. Earlier rows sit in
// one line memory, one word per column holding a sample of each of the
// previous MAX_KERNEL-1 rows. It is read and written at the column of every
// accepted item in the same cycle. A column reduction, a window reduction over
// the column results and two reciprocal multiplies follow in registered
// stages ahead of the output register. One item is taken per cycle; the
// pipeline moves as a whole and halts while a result waits at the output, so
// s_axis_tready follows m_axis_tready once the output register is full.
// After reset the registers hold 64, 64, 2, 2, 2, 2, 0 and the plane
// counters are zero; the line memory needs no clearing.
`default_nettype none
module pool2d_max_avg
  import pool2d_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  input  wire logic [15:0]          s_axis_tdata,   // [15:0] sample
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  output      logic [39:0]          m_axis_tdata,   // [15:0] pooled_value, [25:16] out_row,
                                                    // [35:26] out_col, zero above
  output      logic                 m_axis_tlast,   // last_in_plane
  input  wire logic                 cfg_valid_i,
  output      logic                 cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int NS     = MAX_KERNEL - 1;
  localparam int SLOT_W = (NS > 1) ? $clog2(NS) : 1;
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1) + 1;

  // Configuration registers.
  logic [10:0] fw_q, fh_q;
  logic [3:0]  kw_q, kh_q, sw_q, sh_q;
  logic        mode_q;

  logic [WW-1:0]     w_eff;
  logic [11:0]       h_eff;
  logic [KDIM_W-1:0] kw_eff, kh_eff;
  logic [3:0]        sw_eff, sh_eff;

  always_comb begin
    if (fw_q == 11'd0) w_eff = WW'(1);
    else if (32'(fw_q) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(fw_q);
    if (fh_q == 11'd0) h_eff = 12'd1;
    else if (32'(fh_q) > MAX_HEIGHT) h_eff = 12'(MAX_HEIGHT);
    else h_eff = 12'(fh_q);
    if (kw_q == 4'd0) kw_eff = KDIM_W'(1);
    else if (32'(kw_q) > MAX_KERNEL) kw_eff = KDIM_W'(MAX_KERNEL);
    else kw_eff = KDIM_W'(kw_q);
    if (kh_q == 4'd0) kh_eff = KDIM_W'(1);
    else if (32'(kh_q) > MAX_KERNEL) kh_eff = KDIM_W'(MAX_KERNEL);
    else kh_eff = KDIM_W'(kh_q);
    sw_eff = (sw_q == 4'd0) ? 4'd1 : sw_q;
    sh_eff = (sh_q == 4'd0) ? 4'd1 : sh_q;
  end

  logic adv, in_acc, cfg_acc;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;
  assign cfg_ready_o   = 1'b1;
  assign cfg_acc       = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= 11'd64; fh_q <= 11'd64;
      kw_q <= 4'd2; kh_q <= 4'd2; sw_q <= 4'd2; sh_q <= 4'd2;
      mode_q <= MODE_MAX;
    end else if (cfg_acc) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:   fw_q <= cfg_data_i;
        REG_FRAME_HEIGHT:  fh_q <= cfg_data_i;
        REG_KERNEL_WIDTH:  kw_q <= cfg_data_i[3:0];
        REG_KERNEL_HEIGHT: kh_q <= cfg_data_i[3:0];
        REG_STRIDE_WIDTH:  sw_q <= cfg_data_i[3:0];
        REG_STRIDE_HEIGHT: sh_q <= cfg_data_i[3:0];
        REG_POOL_MODE:     mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Plane position and window phase counters.
  logic [AW-1:0]     c_q, c_d;
  logic [ROW_W-1:0]  r_q, r_d;
  logic [SLOT_W-1:0] rslot_q, rslot_d;
  logic [3:0]        cph_q, cph_d, rph_q, rph_d;
  logic [ROW_W-1:0]  ocol_q, ocol_d, orow_q, orow_d;
  logic              col_in, row_in, hit0;
  tag_t              tag0;

  always_comb begin
    col_in = (WW'(c_q) + WW'(1)) >= WW'(kw_eff);
    row_in = (12'(r_q) + 12'd1) >= 12'(kh_eff);
    hit0   = col_in && row_in && (cph_q == 4'd0) && (rph_q == 4'd0);
    tag0.orow = orow_q;
    tag0.ocol = ocol_q;
    tag0.last = ((WW'(c_q) + WW'(sw_eff)) >= w_eff) && ((12'(r_q) + 12'(sh_eff)) >= h_eff);

    c_d = c_q; r_d = r_q; rslot_d = rslot_q;
    cph_d = cph_q; rph_d = rph_q; ocol_d = ocol_q; orow_d = orow_q;
    if ((WW'(c_q) + WW'(1)) >= w_eff) begin
      c_d = '0; cph_d = '0; ocol_d = '0;
      if ((12'(r_q) + 12'd1) >= h_eff) begin
        r_d = '0; rslot_d = '0; rph_d = '0; orow_d = '0;
      end else begin
        r_d = r_q + ROW_W'(1);
        rslot_d = (32'(rslot_q) + 1 >= NS) ? '0 : rslot_q + SLOT_W'(1);
        if (row_in) begin
          rph_d  = ((5'(rph_q) + 5'd1) == 5'(sh_eff)) ? 4'd0 : rph_q + 4'd1;
          orow_d = (rph_q == 4'd0) ? orow_q + ROW_W'(1) : orow_q;
        end
      end
    end else begin
      c_d = c_q + AW'(1);
      if (col_in) begin
        cph_d  = ((5'(cph_q) + 5'd1) == 5'(sw_eff)) ? 4'd0 : cph_q + 4'd1;
        ocol_d = (cph_q == 4'd0) ? ocol_q + ROW_W'(1) : ocol_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_q <= '0; r_q <= '0; rslot_q <= '0;
      cph_q <= '0; rph_q <= '0; ocol_q <= '0; orow_q <= '0;
    end else if (cfg_acc) begin
      c_q <= '0; r_q <= '0; rslot_q <= '0;
      cph_q <= '0; rph_q <= '0; ocol_q <= '0; orow_q <= '0;
    end else if (in_acc) begin
      c_q <= c_d; r_q <= r_d; rslot_q <= rslot_d;
      cph_q <= cph_d; rph_q <= rph_d; ocol_q <= ocol_d; orow_q <= orow_d;
    end
  end

  // Line memory: reads return the word as it was before this item's write.
  logic [NS-1:0][SAMPLE_W-1:0] line_mem [MAX_WIDTH];
  logic [NS-1:0][SAMPLE_W-1:0] line_rd_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      line_rd_q <= line_mem[c_q];
      line_mem[c_q][rslot_q] <= s_axis_tdata;
    end
  end

  // Stage 1: column of kh samples, reduced to a maximum and a sum.
  logic                s1_valid_q, s1_hit_q;
  logic [SAMPLE_W-1:0] s1_sample_q;
  logic [SLOT_W-1:0]   s1_rslot_q;
  tag_t                s1_tag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_valid_q <= 1'b0;
    else if (adv) s1_valid_q <= in_acc;
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sample_q <= s_axis_tdata;
      s1_rslot_q  <= rslot_q;
      s1_hit_q    <= hit0;
      s1_tag_q    <= tag0;
    end
  end

  logic signed [SAMPLE_W-1:0] col_max, v;
  logic signed [SUM_W-1:0]    col_sum;
  int                         slot_i;

  always_comb begin
    col_max = $signed(s1_sample_q);
    col_sum = SUM_W'($signed(s1_sample_q));
    for (int i = 1; i < MAX_KERNEL; i++) begin
      slot_i = int'(s1_rslot_q) + NS - i;
      if (slot_i >= NS) slot_i = slot_i - NS;
      v = $signed(line_rd_q[SLOT_W'(slot_i)]);
      if (i < int'(kh_eff)) begin
        if (v > col_max) col_max = v;
        col_sum = col_sum + SUM_W'(v);
      end
    end
  end

  // Stage 2: shift line of column results, reduced over kw columns.
  logic signed [SAMPLE_W-1:0] cmax_q [MAX_KERNEL];
  logic signed [SUM_W-1:0]    csum_q [MAX_KERNEL];
  logic                       s2_valid_q;
  tag_t                       s2_tag_q;

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      cmax_q[0] <= col_max;
      csum_q[0] <= col_sum;
      for (int j = 1; j < MAX_KERNEL; j++) begin
        cmax_q[j] <= cmax_q[j-1];
        csum_q[j] <= csum_q[j-1];
      end
    end
    if (adv) s2_tag_q <= s1_tag_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_valid_q <= 1'b0;
    else if (adv) s2_valid_q <= s1_valid_q && s1_hit_q;
  end

  logic signed [SAMPLE_W-1:0] win_max;
  logic signed [SUM_W-1:0]    win_sum;
  logic [SUM_W-1:0]           win_mag;

  always_comb begin
    win_max = cmax_q[0];
    win_sum = csum_q[0];
    for (int j = 1; j < MAX_KERNEL; j++) begin
      if (j < int'(kw_eff)) begin
        if (cmax_q[j] > win_max) win_max = cmax_q[j];
        win_sum = win_sum + csum_q[j];
      end
    end
    win_mag = win_sum[SUM_W-1] ? SUM_W'(-win_sum) : SUM_W'(win_sum);
  end

  // Stages 3 and 4: divide the magnitude by kw, then by kh.
  logic                s3_valid_q, s4_valid_q;
  tag_t                s3_tag_q, s4_tag_q;
  logic [SAMPLE_W-1:0] s3_max_q, s4_max_q;
  logic [SUM_W-1:0]    s3_mag_q, s4_q1_q;
  logic                s3_neg_q, s4_neg_q;
  logic [SUM_W+RECIP_W-1:0] prod1, prod2;
  logic [SUM_W-1:0]    q2;
  logic [SAMPLE_W-1:0] avg_val;

  assign prod1   = (SUM_W+RECIP_W)'(s3_mag_q) * (SUM_W+RECIP_W)'(recip(kw_eff));
  assign prod2   = (SUM_W+RECIP_W)'(s4_q1_q) * (SUM_W+RECIP_W)'(recip(kh_eff));
  assign q2      = prod2[RECIP_SH +: SUM_W];
  assign avg_val = s4_neg_q ? SAMPLE_W'(-q2) : SAMPLE_W'(q2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0; s4_valid_q <= 1'b0; m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      s3_valid_q <= s2_valid_q; s4_valid_q <= s3_valid_q; m_axis_tvalid <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_tag_q <= s2_tag_q; s3_max_q <= win_max;
      s3_mag_q <= win_mag; s3_neg_q <= win_sum[SUM_W-1];
      s4_tag_q <= s3_tag_q; s4_max_q <= s3_max_q;
      s4_q1_q  <= prod1[RECIP_SH +: SUM_W]; s4_neg_q <= s3_neg_q;
      m_axis_tdata <= {4'd0, s4_tag_q.ocol, s4_tag_q.orow,
                       (mode_q == MODE_MAX) ? s4_max_q : avg_val};
      m_axis_tlast <= s4_tag_q.last;
    end
  end

  // A waiting result halts the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while a result is stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni) 32'(rslot_q) < NS)
    else $error("row slot out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni) WW'(c_q) < w_eff)
    else $error("column counter beyond frame width");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cph_q < sw_eff) && (rph_q < sh_eff))
    else $error("stride phase out of range");

endmodule
`default_nettype wire
